FILE: design/ppd_pkg.sv
// Shared types and constants for the pairwise point distance unit.
`default_nettype none

package ppd_pkg;

	localparam int IDX_W  = 6;
	localparam int DIST_W = 17;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic             last;
		logic             full;
	} tag_t;

	localparam int TAG_W = $bits(tag_t);

endpackage

`default_nettype wire

FILE: design/ppd_fifo.sv
// Small register queue between the front and back halves.
`default_nettype none

module ppd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] head,
	output logic                  empty,
	output logic                  full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(DEPTH));
	assign head  = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

FILE: design/ppd_front.sv
// Input side: point counting, new-set handling and store-full classification.
`default_nettype none

module ppd_front #(
	parameter int MAX_POINTS = 64,
	parameter int CW         = 16,
	parameter int IW         = 6,
	parameter int CMD_W      = 1 + IW + 2 * CW
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              point_valid,
	output logic                   point_stall,
	input  wire logic [15:0]       x_coord,
	input  wire logic [15:0]       y_coord,
	input  wire logic              new_set,
	input  wire logic              q_full,
	output logic                   q_push,
	output logic      [CMD_W-1:0]  q_data
);

	localparam int NW = $clog2(MAX_POINTS + 1);

	logic [NW-1:0] count_q;
	logic [NW-1:0] slot;
	logic          is_full;
	logic [CW-1:0] xw;
	logic [CW-1:0] yw;

	assign point_stall = q_full;
	assign q_push      = point_valid && !q_full;
	assign slot        = new_set ? '0 : count_q;
	assign is_full     = (slot == NW'(MAX_POINTS));
	assign xw          = x_coord[CW-1:0];
	assign yw          = y_coord[CW-1:0];
	assign q_data      = {is_full, IW'(slot), xw, yw};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (q_push && !is_full) begin
			count_q <= slot + 1'b1;
		end else if (q_push && new_set) begin
			count_q <= '0;
		end
	end

endmodule

`default_nettype wire

FILE: design/ppd_sqrt.sv
// Pipelined integer square root, one root bit per stage, with remainder.
`default_nettype none

module ppd_sqrt #(
	parameter int RW  = 17,
	parameter int AW  = 8,
	parameter int QPW = 2 * RW
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_vld,
	input  wire logic [QPW-1:0] in_q,
	input  wire logic [AW-1:0]  in_aux,
	output logic                out_vld,
	output logic      [RW-1:0]  out_root,
	output logic      [RW:0]    out_rem,
	output logic      [AW-1:0]  out_aux
);

	logic           vld_a  [RW+1];
	logic [RW-1:0]  root_a [RW+1];
	logic [RW:0]    rem_a  [RW+1];
	logic [QPW-1:0] q_a    [RW+1];
	logic [AW-1:0]  aux_a  [RW+1];

	assign vld_a[0]  = in_vld;
	assign root_a[0] = '0;
	assign rem_a[0]  = '0;
	assign q_a[0]    = in_q;
	assign aux_a[0]  = in_aux;

	for (genvar i = 0; i < RW; i++) begin : g_stage
		logic [RW+2:0] cur;
		logic [RW+2:0] trial;
		logic [RW+2:0] diff;
		logic          take;

		always_comb begin
			cur   = {rem_a[i], q_a[i][QPW-1 -: 2]};
			trial = {1'b0, root_a[i], 2'b01};
			take  = (cur >= trial);
			diff  = cur - trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_a[i+1] <= 1'b0;
			end else if (en) begin
				vld_a[i+1] <= vld_a[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_a[i+1] <= {root_a[i][RW-2:0], take};
				rem_a[i+1]  <= take ? diff[RW:0] : cur[RW:0];
				q_a[i+1]    <= {q_a[i][QPW-3:0], 2'b00};
				aux_a[i+1]  <= aux_a[i];
			end
		end
	end

	assign out_vld  = vld_a[RW];
	assign out_root = root_a[RW];
	assign out_rem  = rem_a[RW];
	assign out_aux  = aux_a[RW];

endmodule

`default_nettype wire

FILE: design/ppd_back.sv
// Execution side: point store, row sequencer, distance pipeline and output register.
`default_nettype none

module ppd_back
	import ppd_pkg::*;
#(
	parameter int MAX_POINTS = 64,
	parameter int CW         = 16,
	parameter int IW         = 6,
	parameter int CMD_W      = 1 + IW + 2 * CW
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              metric_mode,
	input  wire logic              q_empty,
	input  wire logic [CMD_W-1:0]  q_head,
	output logic                   q_pop,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic      [IDX_W-1:0]  row_index,
	output logic      [IDX_W-1:0]  col_index,
	output logic      [DIST_W-1:0] distance,
	output logic                   last,
	output logic                   store_full
);

	localparam int RW  = CW + 1;
	localparam int QW  = 2 * CW + 1;
	localparam int QPW = 2 * RW;
	localparam int MW  = CW + 1;
	localparam int AXW = TAG_W + MW;
	localparam int EW  = (RW + 1 > DIST_W) ? RW + 1 : DIST_W;

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t        state_q;
	logic          en;
	logic          h_full;
	logic [IW-1:0] h_row;
	logic [CW-1:0] h_x;
	logic [CW-1:0] h_y;

	logic [IW-1:0] row_q;
	logic [IW-1:0] k_q;
	logic [CW-1:0] cx_q;
	logic [CW-1:0] cy_q;

	logic [CW-1:0] xs_mem [MAX_POINTS];
	logic [CW-1:0] ys_mem [MAX_POINTS];

	logic          vld_s1;
	tag_t          tag_s1;
	logic [CW-1:0] rx_s1, ry_s1, cx_s1, cy_s1;

	logic              vld_s2;
	tag_t              tag_s2;
	logic [CW-1:0]     adx_s2, ady_s2;
	logic signed [CW:0] ddx, ddy;

	logic            vld_s3;
	tag_t            tag_s3;
	logic [2*CW-1:0] sqx_s3, sqy_s3;
	logic [MW-1:0]   man_s3;

	logic          vld_s4;
	tag_t          tag_s4;
	logic [QW-1:0] q_s4;
	logic [MW-1:0] man_s4;

	logic           sq_vld;
	logic [RW-1:0]  sq_root;
	logic [RW:0]    sq_rem;
	logic [AXW-1:0] sq_aux;
	tag_t           sq_tag;
	logic [MW-1:0]  sq_man;
	logic           round_up;
	logic [EW-1:0]  dist_e;

	assign en = !(result_valid && result_stall);
	assign {h_full, h_row, h_x, h_y} = q_head;
	assign q_pop = en && (state_q == ST_IDLE) && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			vld_s1  <= 1'b0;
			tag_s1  <= '0;
			row_q   <= '0;
			k_q     <= '0;
		end else if (en) begin
			vld_s1 <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						if (h_full) begin
							vld_s1 <= 1'b1;
							tag_s1 <= '{row: '0, col: '0, last: 1'b1, full: 1'b1};
						end else begin
							row_q   <= h_row;
							k_q     <= '0;
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					vld_s1 <= 1'b1;
					tag_s1 <= '{row: IDX_W'(row_q), col: IDX_W'(k_q),
						last: (k_q == row_q), full: 1'b0};
					if (k_q == row_q) begin
						state_q <= ST_IDLE;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// point store: written when a row starts, read once per column
	always_ff @(posedge clk) begin
		if (q_pop && !h_full) begin
			xs_mem[h_row] <= h_x;
			ys_mem[h_row] <= h_y;
			cx_q          <= h_x;
			cy_q          <= h_y;
		end
		if (en) begin
			rx_s1 <= xs_mem[k_q];
			ry_s1 <= ys_mem[k_q];
			cx_s1 <= cx_q;
			cy_s1 <= cy_q;
		end
	end

	always_comb begin
		ddx = $signed({cx_s1[CW-1], cx_s1}) - $signed({rx_s1[CW-1], rx_s1});
		ddy = $signed({cy_s1[CW-1], cy_s1}) - $signed({ry_s1[CW-1], ry_s1});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s2 <= tag_s1;
			adx_s2 <= ddx[CW] ? CW'(-ddx) : CW'(ddx);
			ady_s2 <= ddy[CW] ? CW'(-ddy) : CW'(ddy);

			tag_s3 <= tag_s2;
			sqx_s3 <= (2*CW)'(adx_s2) * (2*CW)'(adx_s2);
			sqy_s3 <= (2*CW)'(ady_s2) * (2*CW)'(ady_s2);
			man_s3 <= MW'(adx_s2) + MW'(ady_s2);

			tag_s4 <= tag_s3;
			q_s4   <= QW'(sqx_s3) + QW'(sqy_s3);
			man_s4 <= man_s3;
		end
	end

	ppd_sqrt #(
		.RW  (RW),
		.AW  (AXW),
		.QPW (QPW)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4),
		.in_q     (QPW'(q_s4)),
		.in_aux   ({tag_s4, man_s4}),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_rem  (sq_rem),
		.out_aux  (sq_aux)
	);

	// round to nearest: bump the root when the remainder exceeds it
	always_comb begin
		{sq_tag, sq_man} = sq_aux;
		round_up = (sq_rem > {1'b0, sq_root});
		if (metric_mode) begin
			dist_e = EW'(sq_man);
		end else begin
			dist_e = EW'(sq_root) + EW'(round_up);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (en) begin
			result_valid <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_index  <= sq_tag.row;
			col_index  <= sq_tag.col;
			last       <= sq_tag.last;
			store_full <= sq_tag.full;
			if (sq_tag.full) begin
				distance <= '0;
			end else if (dist_e > EW'(DIST_MAX)) begin
				distance <= DIST_MAX;
			end else begin
				distance <= dist_e[DIST_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/pairwise_point_distance_unit.sv
// Pairwise point distance unit: top level with config register and assertions.
// Each word passes the row sequencer, stages s1-s4, ppd_sqrt and the output register.
// Throughput: a point of store index n yields n+1 words (a dropped point one), set by
//   the row sequencer reading one stored point per cycle unless the output stalls.
// A 4-entry command queue lets points be taken while the previous row is still running.
// Reset (arst_n low) empties the store and queue and sets metric_mode to Euclidean.
`default_nettype none

module pairwise_point_distance_unit
	import ppd_pkg::*;
#(
	parameter int MAX_POINTS = 64,
	parameter int COORD_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              metric_mode,
	input  wire logic              point_valid,
	output logic                   point_stall,
	input  wire logic [15:0]       x_coord,
	input  wire logic [15:0]       y_coord,
	input  wire logic              new_set,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic      [IDX_W-1:0]  row_index,
	output logic      [IDX_W-1:0]  col_index,
	output logic      [DIST_W-1:0] distance,
	output logic                   last,
	output logic                   store_full
);

	localparam int CW    = (COORD_BITS < 16) ? COORD_BITS : 16;
	localparam int IW    = $clog2(MAX_POINTS);
	localparam int CMD_W = 1 + IW + 2 * CW;

	logic             metric_mode_q;
	logic             q_push;
	logic             q_pop;
	logic             q_empty;
	logic             q_full;
	logic [CMD_W-1:0] q_in;
	logic [CMD_W-1:0] q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			metric_mode_q <= metric_mode;
		end
	end

	ppd_front #(
		.MAX_POINTS (MAX_POINTS),
		.CW         (CW),
		.IW         (IW),
		.CMD_W      (CMD_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.new_set     (new_set),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_in)
	);

	ppd_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (4)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	ppd_back #(
		.MAX_POINTS (MAX_POINTS),
		.CW         (CW),
		.IW         (IW),
		.CMD_W      (CMD_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.metric_mode  (metric_mode_q),
		.q_empty      (q_empty),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.row_index    (row_index),
		.col_index    (col_index),
		.distance     (distance),
		.last         (last),
		.store_full   (store_full)
	);

	a_full_word: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && store_full |-> distance == '0 && last && row_index == '0)
		else $error("dropped point word malformed");

	a_col_le_row: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !store_full |-> col_index <= row_index)
		else $error("column beyond row");

	a_last_diag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !store_full |-> last == (col_index == row_index))
		else $error("last flag off the diagonal");

	a_diag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !store_full && col_index == row_index |-> distance == '0)
		else $error("nonzero self distance");

endmodule

`default_nettype wire

FILE: dv/pairwise_point_distance_unit_tb.sv
// Testbench for the pairwise point distance unit, checked against an in-bench predictor.
`timescale 1ns / 1ps

module pairwise_point_distance_unit_tb
	import ppd_pkg::*;
();

	localparam int MAX_POINTS = 64;
	localparam int COORD_BITS = 16;
	localparam int CW         = (COORD_BITS < 16) ? COORD_BITS : 16;
	localparam longint DIST_SAT = 131071;
	localparam int PIPE_WAIT   = 40;
	localparam int DRAIN_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int ITEM_TARGET = 370;

	localparam bit METRIC_EUCLID    = 1'b0;
	localparam bit METRIC_MANHATTAN = 1'b1;

	typedef struct packed {
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [DIST_W-1:0] dval;
		logic              last;
		logic              full;
	} dist_word_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic              metric_mode;
	logic              point_valid;
	logic              point_stall;
	logic [15:0]       x_coord;
	logic [15:0]       y_coord;
	logic              new_set;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic [IDX_W-1:0]  row_index;
	logic [IDX_W-1:0]  col_index;
	logic [DIST_W-1:0] distance;
	logic              last;
	logic              store_full;

	// predictor state
	longint      x_pts [MAX_POINTS];
	longint      y_pts [MAX_POINTS];
	int unsigned n_pts;
	bit          mode_m;

	dist_word_t dist_q [$];

	int  fails;
	int  points_sent;
	int  words_seen;
	int  drops_expected;
	int  in_stall_cycles;
	int  rx_wait;
	int  hold_left = 0;
	bit  hold_req = 1'b0;
	bit  tx_idle;
	bit  rx_idle;

	pairwise_point_distance_unit #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.metric_mode (metric_mode),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.new_set     (new_set),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.row_index   (row_index),
		.col_index   (col_index),
		.distance    (distance),
		.last        (last),
		.store_full  (store_full)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint wrap_coord(input logic signed [15:0] v);
		logic signed [15:0] w;
		w = v <<< (16 - CW);
		w = w >>> (16 - CW);
		return longint'(w);
	endfunction

	function automatic logic [DIST_W-1:0] point_gap(input bit manh, input longint x1,
			input longint y1, input longint x2, input longint y2);
		longint dx, dy, q, s, t, d;
		dx = (x1 > x2) ? x1 - x2 : x2 - x1;
		dy = (y1 > y2) ? y1 - y2 : y2 - y1;
		if (manh) begin
			d = dx + dy;
		end else begin
			q = dx * dx + dy * dy;
			s = 0;
			for (int b = 20; b >= 0; b--) begin
				t = s | (longint'(1) << b);
				if (t * t <= q)
					s = t;
			end
			// round to nearest
			if (q - s * s > s)
				s++;
			d = s;
		end
		if (d > DIST_SAT)
			d = DIST_SAT;
		return d[DIST_W-1:0];
	endfunction

	task automatic predict_row(input logic signed [15:0] x, input logic signed [15:0] y,
			input bit ns);
		dist_word_t w;
		longint px, py;
		int unsigned n;
		px = wrap_coord(x);
		py = wrap_coord(y);
		if (ns)
			n_pts = 0;
		if (n_pts >= MAX_POINTS) begin
			w = '0;
			w.last = 1'b1;
			w.full = 1'b1;
			dist_q.insert(dist_q.size(), w);
			drops_expected++;
			return;
		end
		n = n_pts;
		x_pts[n] = px;
		y_pts[n] = py;
		n_pts = n + 1;
		for (int unsigned k = 0; k <= n; k++) begin
			w.row  = n[IDX_W-1:0];
			w.col  = k[IDX_W-1:0];
			w.dval = point_gap(mode_m, px, py, x_pts[k], y_pts[k]);
			w.last = (k == n);
			w.full = 1'b0;
			dist_q.insert(dist_q.size(), w);
		end
	endtask

	// result checker
	always @(posedge clk) begin : chk
		dist_word_t got, want;
		if (arst_n && result_valid && !result_stall) begin
			got = {row_index, col_index, distance, last, store_full};
			words_seen++;
			if (dist_q.size() == 0) begin
				fails++;
				if (fails <= 10)
					$display("unexpected word @%0t: row %0d col %0d dist %0d last %0b full %0b",
						$time, got.row, got.col, got.dval, got.last, got.full);
			end else begin
				want = dist_q.pop_front();
				if (got !== want) begin
					fails++;
					if (fails <= 10)
						$display({"mismatch @%0t (exp/got): row %0d/%0d col %0d/%0d ",
							"dist %0d/%0d last %0b/%0b full %0b/%0b"}, $time,
							want.row, got.row, want.col, got.col, want.dval, got.dval,
							want.last, got.last, want.full, got.full);
				end
			end
		end
	end

	// long output hold-off
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (hold_req) begin
			hold_left <= HOLD_CYCLES;
			hold_req  <= 1'b0;
		end
	end

	// receiver stall
	always @(posedge clk) begin
		if (result_valid && !result_stall)
			rx_wait = rx_idle ? $urandom_range(0, 3) : 0;
		if (hold_left != 0) begin
			result_stall <= 1'b1;
		end else if (rx_wait != 0) begin
			result_stall <= 1'b1;
			rx_wait--;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (point_valid && point_stall)
			in_stall_cycles++;
	end

	task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
			input bit ns);
		int gap;
		gap = tx_idle ? $urandom_range(0, 3) : 0;
		if (gap != 0) begin
			point_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		point_valid <= 1'b1;
		x_coord     <= x;
		y_coord     <= y;
		new_set     <= ns;
		@(posedge clk);
		while (point_stall)
			@(posedge clk);
		predict_row(x, y, ns);
		points_sent++;
	endtask

	task automatic wait_idle;
		int spins;
		point_valid <= 1'b0;
		spins = 0;
		while (dist_q.size() != 0 && spins < DRAIN_LIMIT) begin
			@(posedge clk);
			spins++;
		end
		repeat (PIPE_WAIT) @(posedge clk);
	endtask

	task automatic set_metric(input bit m);
		wait_idle();
		cfg_valid   <= 1'b1;
		metric_mode <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		mode_m = m;
	endtask

	function automatic logic [15:0] rand_coord();
		logic [15:0] v;
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 3))
					0: v = 16'h8000;
					1: v = 16'h7fff;
					2: v = 16'h0000;
					default: v = 16'hffff;
				endcase
			end
			1, 2: v = 16'($signed($urandom_range(0, 40)) - 20);
			default: v = 16'($urandom());
		endcase
		return v;
	endfunction

	task automatic test_euclid_corners;
		set_metric(METRIC_EUCLID);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_point(16'sd0, 16'sd0, 1'b1);
		send_point(16'sd3, 16'sd4, 1'b0);
		send_point(16'sd1, 16'sd1, 1'b0);
		send_point(16'sd2, 16'sd2, 1'b0);
		send_point(16'sd2, 16'sd3, 1'b0);
		send_point(-16'sd32768, -16'sd32768, 1'b0);
		send_point(16'sd32767, 16'sd32767, 1'b0);
		send_point(16'sd32767, -16'sd32768, 1'b0);
		send_point(-16'sd32768, 16'sd32767, 1'b0);
		send_point(-16'sd1, -16'sd1, 1'b0);
		wait_idle();
	endtask

	task automatic test_manhattan_corners;
		set_metric(METRIC_MANHATTAN);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		send_point(-16'sd32768, -16'sd32768, 1'b1);
		send_point(16'sd32767, 16'sd32767, 1'b0);
		send_point(-16'sd32768, 16'sd32767, 1'b0);
		send_point(16'sd32767, -16'sd32768, 1'b0);
		send_point(16'sd0, 16'sd0, 1'b0);
		send_point(-16'sd1, 16'sd0, 1'b0);
		wait_idle();
	endtask

	task automatic test_store_full;
		set_metric(1'($urandom_range(0, 1)));
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_point(rand_coord(), rand_coord(), 1'b1);
		for (int i = 1; i < MAX_POINTS; i++)
			send_point(rand_coord(), rand_coord(), 1'b0);
		// store is full now
		for (int i = 0; i < 3; i++)
			send_point(rand_coord(), rand_coord(), 1'b0);
		send_point(rand_coord(), rand_coord(), 1'b1);
		send_point(rand_coord(), rand_coord(), 1'b0);
		wait_idle();
	endtask

	task automatic test_output_backpressure;
		set_metric(METRIC_EUCLID);
		tx_idle  = 1'b0;
		rx_idle  = 1'b0;
		hold_req <= 1'b1;
		send_point(rand_coord(), rand_coord(), 1'b1);
		for (int i = 1; i < 24; i++)
			send_point(rand_coord(), rand_coord(), 1'b0);
		wait_idle();
	endtask

	task automatic test_random_sets;
		int set_len;
		bit ns;
		while (points_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 3) == 0)
				set_metric(1'($urandom_range(0, 1)));
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 16);
			for (int k = 0; k < set_len; k++) begin
				// now and then a set carries on from the previous one
				ns = (k == 0) && ($urandom_range(0, 7) != 0);
				send_point(rand_coord(), rand_coord(), ns);
			end
		end
		wait_idle();
	endtask

	initial begin
		arst_n      = 1'b0;
		cfg_valid   = 1'b0;
		metric_mode = 1'b0;
		point_valid = 1'b0;
		x_coord     = '0;
		y_coord     = '0;
		new_set     = 1'b0;
		tx_idle     = 1'b1;
		rx_idle     = 1'b1;
		rx_wait     = 0;
		n_pts       = 0;
		mode_m      = METRIC_EUCLID;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_euclid_corners();
		test_manhattan_corners();
		test_store_full();
		test_output_backpressure();
		test_random_sets();
		set_metric(METRIC_EUCLID);
		wait_idle();
		fails += dist_q.size();

		$display("Sent %0d points over both metrics, %0d of them dropped on a full store;",
			points_sent, drops_expected);
		$display("checked %0d distance words, input stalled for %0d cycles under back-pressure.",
			words_seen, in_stall_cycles);
		if (fails == 0)
			$display("pairwise_point_distance_unit_tb OK");
		else
			$display("pairwise_point_distance_unit_tb NOT OK");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("timeout");
		$display("pairwise_point_distance_unit_tb NOT OK");
		$finish;
	end

endmodule
